// File: rtl/rbd_pkg.sv
// ============================================================================
// rbd_pkg: shared types and constants of the ring buffer deque
// Holds the request codes, the decoded operation and result records, and the
// field widths used by the front, queue and back modules.
// ============================================================================
package rbd_pkg;

    localparam int CAPACITY_DEF   = 1024;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int REQ_TYPE_W   = 4;
    localparam int VALUE_W      = 32;
    localparam int POSITION_W   = 10;
    localparam int NEW_LENGTH_W = 11;
    localparam int DATA_OUT_W   = 32;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 11;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;
    localparam int S_PAD_W   = S_TDATA_W - VALUE_W - POSITION_W - NEW_LENGTH_W;
    localparam int M_PAD_W   = M_TDATA_W - DATA_OUT_W - STATUS_W - COUNT_W - 1;

    // Entries in the queue between the front and the back; a power of two.
    localparam int QUEUE_DEPTH = 2;

    // Request codes as they arrive on the input channel.
    localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_BACK  = 4'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_PUSH_FRONT = 4'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_POP_BACK   = 4'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_POP_FRONT  = 4'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_PEEK_FRONT = 4'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_PEEK_BACK  = 4'd5;
    localparam logic [REQ_TYPE_W-1:0] REQ_READ_INDEX = 4'd6;
    localparam logic [REQ_TYPE_W-1:0] REQ_RESIZE     = 4'd7;
    localparam logic [REQ_TYPE_W-1:0] REQ_CLEAR      = 4'd8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PUSH_BACK,
        OP_PUSH_FRONT,
        OP_POP_BACK,
        OP_POP_FRONT,
        OP_PEEK_FRONT,
        OP_PEEK_BACK,
        OP_READ_INDEX,
        OP_RESIZE,
        OP_CLEAR
    } op_kind_t;

    typedef struct packed {
        op_kind_t                  kind;
        logic [VALUE_W-1:0]        value;
        logic [POSITION_W-1:0]     position;
        logic [NEW_LENGTH_W-1:0]   new_length;
    } op_t;

    typedef struct packed {
        logic [DATA_OUT_W-1:0] data_out;
        logic [STATUS_W-1:0]   status;
        logic [COUNT_W-1:0]    count;
        logic                  is_empty;
    } result_t;

endpackage

// File: rtl/ring_buffer_deque_top.sv
// ============================================================================
// ring_buffer_deque_top: double-ended queue in a circular store
// Top level of the deque: unpacks request items, passes them through the
// decode front and the operation queue to the execution back, and packs the
// result items onto the output channel.
// ============================================================================
// Usage:
// Each request item on the s_axis channel (request code in tuser; value,
// position and new length in tdata) gives exactly one result item on the
// m_axis channel, in request order. A result carries the read element (zero
// unless a pop, peek or indexed read succeeded), a status code, the count
// after the request and an empty flag.
// A pop, peek or indexed read takes its result from the slot memory's
// registered read data. A growing resize writes every new slot through
// the single write port of the slot memory, and the back is busy until
// all are written. The back unit runs one item per cycle for writes and
// errors while the output is not stalled; after taking a read it takes no
// new item until the read result is formed, and it stalls on growing
// resizes. The front and a two-entry queue keep taking items while the
// back is busy.
// Reset clears the head and the count; slot contents are left as they are
// and are only read once written. When m_axis_tready is low the result is
// held in the output register, the back stops, and the queue and the front
// fill before s_axis_tready drops.
module ring_buffer_deque_top
    import rbd_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // tdata, from bit 0 up: value[31:0], position[41:32], new_length[52:42], zero pad
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // tuser: req_type[3:0]
    input  logic [REQ_TYPE_W-1:0] s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // tdata, from bit 0 up: data_out[31:0], status[33:32], count[44:34], is_empty[45], zero pad
    output logic [M_TDATA_W-1:0]  m_axis_tdata
);

    localparam int POS_LSB = VALUE_W;
    localparam int LEN_LSB = VALUE_W + POSITION_W;

    op_t     front_op;
    logic    front_valid;
    logic    front_ready;
    op_t     queue_op;
    logic    queue_valid;
    logic    queue_ready;
    result_t back_res;

    // Intake and decode of request items.
    rbd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .req_type   (s_axis_tuser),
        .value      (s_axis_tdata[VALUE_W-1:0]),
        .position   (s_axis_tdata[POS_LSB +: POSITION_W]),
        .new_length (s_axis_tdata[LEN_LSB +: NEW_LENGTH_W]),
        .op_valid   (front_valid),
        .op_ready   (front_ready),
        .op         (front_op)
    );

    // Decouples the front from the back so each side can stall on its own.
    rbd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_op     (front_op),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_op    (queue_op)
    );

    // Executes operations against the head, the count and the slot memory.
    rbd_back #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op_valid  (queue_valid),
        .op_ready  (queue_ready),
        .op        (queue_op),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (back_res)
    );

    assign m_axis_tdata = {
        {M_PAD_W{1'b0}},
        back_res.is_empty,
        back_res.count,
        back_res.status,
        back_res.data_out
    };

endmodule

// File: rtl/rbd_front.sv
// ============================================================================
// rbd_front: request intake and decode
// Takes items from the input channel, turns the request code into an
// operation kind and holds the decoded operation in a one-entry register.
// ============================================================================
module rbd_front
    import rbd_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [REQ_TYPE_W-1:0]   req_type,
    input  logic [VALUE_W-1:0]      value,
    input  logic [POSITION_W-1:0]   position,
    input  logic [NEW_LENGTH_W-1:0] new_length,
    output logic                    op_valid,
    input  logic                    op_ready,
    output op_t                     op
);

    logic     valid_reg;
    op_t      op_reg;
    op_kind_t kind_dec;

    always_comb begin
        case (req_type)
            REQ_PUSH_BACK:  kind_dec = OP_PUSH_BACK;
            REQ_PUSH_FRONT: kind_dec = OP_PUSH_FRONT;
            REQ_POP_BACK:   kind_dec = OP_POP_BACK;
            REQ_POP_FRONT:  kind_dec = OP_POP_FRONT;
            REQ_PEEK_FRONT: kind_dec = OP_PEEK_FRONT;
            REQ_PEEK_BACK:  kind_dec = OP_PEEK_BACK;
            REQ_READ_INDEX: kind_dec = OP_READ_INDEX;
            REQ_RESIZE:     kind_dec = OP_RESIZE;
            REQ_CLEAR:      kind_dec = OP_CLEAR;
            default:        kind_dec = OP_NONE;
        endcase
    end

    assign s_ready  = !valid_reg || op_ready;
    assign op_valid = valid_reg;
    assign op       = op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            valid_reg <= 1'b1;
        end else if (op_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg.kind       <= kind_dec;
            op_reg.value      <= value;
            op_reg.position   <= position;
            op_reg.new_length <= new_length;
        end
    end

endmodule

// File: rtl/rbd_queue.sv
// ============================================================================
// rbd_queue: operation queue between front and back
// A short first-in first-out queue of decoded operations so that the front
// keeps taking items while the back is busy.
// ============================================================================
module rbd_queue
    import rbd_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  op_t  in_op,
    output logic out_valid,
    input  logic out_ready,
    output op_t  out_op
);

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QC_W = $clog2(QUEUE_DEPTH + 1);

    op_t             entry_reg [QUEUE_DEPTH];
    logic [QP_W-1:0] wr_ptr_reg;
    logic [QP_W-1:0] rd_ptr_reg;
    logic [QC_W-1:0] used_reg;
    logic            push;
    logic            pop;

    assign in_ready  = used_reg != QC_W'(QUEUE_DEPTH);
    assign out_valid = used_reg != '0;
    assign out_op    = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            used_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                used_reg <= used_reg + 1'b1;
            end else if (pop && !push) begin
                used_reg <= used_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

// File: rtl/rbd_back.sv
// ============================================================================
// rbd_back: deque execution unit
// Holds the head pointer, the fill count and the slot memory, carries out one
// operation at a time and keeps the result in an output register.
// ============================================================================
module rbd_back
    import rbd_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    op_valid,
    output logic    op_ready,
    input  op_t     op,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    localparam int PTR_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = ((CNT_W > NEW_LENGTH_W) ? CNT_W : NEW_LENGTH_W) + 1;
    localparam logic [SUM_W-1:0] CAP_S    = SUM_W'(CAPACITY);
    localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(CAPACITY - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_FILL
    } state_t;

    state_t               state_reg, state_next;
    logic [PTR_W-1:0]     head_reg, head_next;
    logic [CNT_W-1:0]     fill_reg, fill_next;
    logic [PTR_W-1:0]     wp_reg, wp_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic [DATA_WIDTH-1:0] fill_val_reg, fill_val_next;
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    logic [DATA_WIDTH-1:0] slots_mem [CAPACITY];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr;
    logic [DATA_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [PTR_W-1:0]      rd_addr;

    logic [SUM_W-1:0]      head_s;
    logic [SUM_W-1:0]      fill_s;
    logic [SUM_W-1:0]      len_s;
    logic [SUM_W-1:0]      pos_s;
    logic [PTR_W-1:0]      back_idx;
    logic [PTR_W-1:0]      tail_idx;
    logic [PTR_W-1:0]      pos_idx;
    logic [PTR_W-1:0]      head_dec;
    logic [PTR_W-1:0]      head_inc;
    logic [DATA_WIDTH-1:0] op_val;
    logic                  is_full;
    logic                  is_zero;
    logic                  take;
    logic [STATUS_W-1:0]   status_v;

    // Sums stay below twice the capacity, so one compare and subtract wraps them.
    function automatic logic [PTR_W-1:0] wrap_idx(input logic [SUM_W-1:0] a);
        logic [SUM_W-1:0] r;
        r = (a >= CAP_S) ? a - CAP_S : a;
        return r[PTR_W-1:0];
    endfunction

    assign head_s   = SUM_W'(head_reg);
    assign fill_s   = SUM_W'(fill_reg);
    assign len_s    = SUM_W'(op.new_length);
    assign pos_s    = SUM_W'(op.position);
    assign back_idx = wrap_idx(head_s + fill_s - 1'b1);
    assign tail_idx = wrap_idx(head_s + fill_s);
    assign pos_idx  = wrap_idx(head_s + pos_s);
    assign head_inc = wrap_idx(head_s + 1'b1);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign op_val   = DATA_WIDTH'(op.value);
    assign is_full  = fill_reg == CNT_W'(CAPACITY);
    assign is_zero  = fill_reg == '0;

    assign op_ready  = (state_reg == S_IDLE) && (!res_valid_reg || res_ready);
    assign take      = op_valid && op_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb begin
        state_next     = state_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        wp_next        = wp_reg;
        left_next      = left_reg;
        fill_val_next  = fill_val_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = op_val;
        rd_en          = 1'b0;
        rd_addr        = '0;
        status_v       = ST_OK;

        case (state_reg)
            S_IDLE: begin
                if (take) begin
                    case (op.kind)
                        OP_PUSH_BACK: begin
                            if (is_full) begin
                                status_v = ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = tail_idx;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_PUSH_FRONT: begin
                            if (is_full) begin
                                status_v = ST_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                wr_addr   = head_dec;
                                head_next = head_dec;
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        OP_POP_BACK: begin
                            if (is_zero) begin
                                status_v = ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = back_idx;
                                fill_next  = fill_reg - 1'b1;
                                state_next = S_READ;
                            end
                        end
                        OP_POP_FRONT: begin
                            if (is_zero) begin
                                status_v = ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                head_next  = head_inc;
                                fill_next  = fill_reg - 1'b1;
                                state_next = S_READ;
                            end
                        end
                        OP_PEEK_FRONT: begin
                            if (is_zero) begin
                                status_v = ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = head_reg;
                                state_next = S_READ;
                            end
                        end
                        OP_PEEK_BACK: begin
                            if (is_zero) begin
                                status_v = ST_EMPTY;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = back_idx;
                                state_next = S_READ;
                            end
                        end
                        OP_READ_INDEX: begin
                            if (is_zero) begin
                                status_v = ST_EMPTY;
                            end else if (pos_s >= fill_s) begin
                                status_v = ST_RANGE;
                            end else begin
                                rd_en      = 1'b1;
                                rd_addr    = pos_idx;
                                state_next = S_READ;
                            end
                        end
                        OP_RESIZE: begin
                            if (len_s > CAP_S) begin
                                status_v = ST_FULL;
                            end else if (len_s > fill_s) begin
                                // Growing: the new back slots are written one per cycle.
                                fill_next     = CNT_W'(op.new_length);
                                wp_next       = tail_idx;
                                left_next     = CNT_W'(len_s - fill_s);
                                fill_val_next = op_val;
                                state_next    = S_FILL;
                            end else begin
                                fill_next = CNT_W'(op.new_length);
                            end
                        end
                        OP_CLEAR: begin
                            fill_next = '0;
                            head_next = '0;
                        end
                        default: begin
                        end
                    endcase

                    res_next.data_out = '0;
                    res_next.status   = status_v;
                    res_next.count    = COUNT_W'(fill_next);
                    res_next.is_empty = fill_next == '0;
                    res_valid_next    = (state_next == S_IDLE);
                end
            end
            S_READ: begin
                res_next.data_out = DATA_OUT_W'(rd_data_reg);
                res_valid_next    = 1'b1;
                state_next        = S_IDLE;
            end
            S_FILL: begin
                wr_en     = 1'b1;
                wr_addr   = wp_reg;
                wr_data   = fill_val_reg;
                wp_next   = wrap_idx(SUM_W'(wp_reg) + 1'b1);
                left_next = left_reg - 1'b1;
                if (left_reg == CNT_W'(1)) begin
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            fill_reg      <= '0;
            res_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            res_valid_reg <= res_valid_next;
        end
        wp_reg       <= wp_next;
        left_reg     <= left_next;
        fill_val_reg <= fill_val_next;
        res_reg      <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slots_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= slots_mem[rd_addr];
        end
    end

endmodule

// File: bench/tb_ring_buffer_deque_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_ring_buffer_deque_top: self-checking bench for the ring buffer deque
// Drives request items into the s_axis channel and checks every result item
// on m_axis against a cycle-free model of the deque that is kept in step with
// each accepted request. A directed part covers the empty, full and range
// cases. A random part follows, in phases that favor filling, draining or a
// mix, with random gaps on both channels and a long output stall.
// ============================================================================
module tb_ring_buffer_deque_top
    import rbd_pkg::*;
();

    localparam int DEPTH        = CAPACITY_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;

    // Request codes past the last defined one must be ignored by the block.
    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN_LO = REQ_TYPE_W'(REQ_CLEAR + 1);
    localparam logic [REQ_TYPE_W-1:0] REQ_UNKNOWN_HI = '1;

    typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} phase_mode_t;

    // Keeps its own copy of the deque, predicts one result per accepted
    // request, and compares the result items in order.
    class deque_scoreboard;
        logic [DATA_WIDTH_DEF-1:0] slot_copy [DEPTH];
        int unsigned front_idx;
        int unsigned held;
        result_t     awaited_results[$];
        int unsigned errors;

        function new();
            front_idx = 0;
            held      = 0;
            errors    = 0;
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        function void note_request(input logic [REQ_TYPE_W-1:0]   req,
                                   input logic [VALUE_W-1:0]      value,
                                   input logic [POSITION_W-1:0]   pos,
                                   input logic [NEW_LENGTH_W-1:0] len);
            result_t want;
            want.data_out = '0;
            want.status   = ST_OK;
            case (req)
                REQ_PUSH_BACK, REQ_PUSH_FRONT: begin
                    if (held >= DEPTH) begin
                        want.status = ST_FULL;
                    end else if (req == REQ_PUSH_BACK) begin
                        slot_copy[(front_idx + held) % DEPTH] = value;
                        held++;
                    end else begin
                        front_idx = (front_idx + DEPTH - 1) % DEPTH;
                        slot_copy[front_idx] = value;
                        held++;
                    end
                end
                REQ_POP_BACK, REQ_PEEK_BACK: begin
                    if (held == 0) begin
                        want.status = ST_EMPTY;
                    end else begin
                        want.data_out = slot_copy[(front_idx + held - 1) % DEPTH];
                        if (req == REQ_POP_BACK)
                            held--;
                    end
                end
                REQ_POP_FRONT, REQ_PEEK_FRONT: begin
                    if (held == 0) begin
                        want.status = ST_EMPTY;
                    end else begin
                        want.data_out = slot_copy[front_idx];
                        if (req == REQ_POP_FRONT) begin
                            front_idx = (front_idx + 1) % DEPTH;
                            held--;
                        end
                    end
                end
                REQ_READ_INDEX: begin
                    if (held == 0)
                        want.status = ST_EMPTY;
                    else if (int'(pos) >= held)
                        want.status = ST_RANGE;
                    else
                        want.data_out = slot_copy[(front_idx + pos) % DEPTH];
                end
                REQ_RESIZE: begin
                    if (int'(len) > DEPTH) begin
                        want.status = ST_FULL;
                    end else begin
                        // Growing fills the new back slots with the value.
                        for (int unsigned k = held; k < len; k++)
                            slot_copy[(front_idx + k) % DEPTH] = value;
                        held = len;
                    end
                end
                REQ_CLEAR: begin
                    held      = 0;
                    front_idx = 0;
                end
                default: ;
            endcase
            want.count    = COUNT_W'(held);
            want.is_empty = (held == 0);
            awaited_results = {awaited_results, want};
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] word);
            result_t got;
            result_t want;
            got.data_out = word[DATA_OUT_W-1:0];
            got.status   = word[DATA_OUT_W +: STATUS_W];
            got.count    = word[DATA_OUT_W + STATUS_W +: COUNT_W];
            got.is_empty = word[DATA_OUT_W + STATUS_W + COUNT_W];
            if (awaited_results.size() == 0) begin
                $error("result item arrived with no request outstanding");
                errors++;
                return;
            end
            want = awaited_results[0];
            awaited_results.delete(0);
            if (got.data_out !== want.data_out) begin
                $error("data_out: expected %h, got %h", want.data_out, got.data_out);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.count !== want.count) begin
                $error("count: expected %0d, got %0d", want.count, got.count);
                errors++;
            end
            if (got.is_empty !== want.is_empty) begin
                $error("is_empty: expected %0b, got %0b", want.is_empty, got.is_empty);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [REQ_TYPE_W-1:0] s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    deque_scoreboard board = new();

    // Gap control shared by the sender, the receiver and the main sequence.
    bit tx_calm       = 1'b0;
    bit rx_calm       = 1'b0;
    int rx_hold       = 0;
    int cycle_count   = 0;

    ring_buffer_deque_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Offers one request item, with random gaps ahead of it unless the
    // sender is in a calm stretch, and records it once it is taken.
    task automatic drive_request(input logic [REQ_TYPE_W-1:0]   req,
                                 input logic [VALUE_W-1:0]      value,
                                 input logic [POSITION_W-1:0]   pos,
                                 input logic [NEW_LENGTH_W-1:0] len);
        while (!tx_calm && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {{S_PAD_W{1'b0}}, len, pos, value};
        do
            @(posedge aclk);
        while (!s_axis_tready);
        board.note_request(req, value, pos, len);
    endtask

    // Result side: checks each taken item, then picks the next ready level.
    // A hold-off request from the main sequence is counted down here.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready)
                board.check_result(m_axis_tdata);
            if (rx_hold > 0) begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= rx_calm || ($urandom_range(0, 99) >= 34);
            end
        end
    end

    // Watchdog: a correct run ends far below this.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        phase_mode_t           mode;
        logic [REQ_TYPE_W-1:0]   req;
        logic [VALUE_W-1:0]      value;
        logic [POSITION_W-1:0]   pos;
        logic [NEW_LENGTH_W-1:0] len;
        int                    held;
        int                    roll;
        int                    push_cut;
        int                    pop_cut;

        mode = MODE_MIX;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Everything that reads or removes fails on an empty store.
        drive_request(REQ_POP_BACK,   '0, '0, '0);
        drive_request(REQ_POP_FRONT,  '0, '0, '0);
        drive_request(REQ_PEEK_FRONT, '0, '0, '0);
        drive_request(REQ_PEEK_BACK,  '0, '0, '0);
        drive_request(REQ_READ_INDEX, '0, '1, '0);
        drive_request(REQ_RESIZE,     '0, '0, '0);
        drive_request(REQ_CLEAR,      '0, '0, '0);
        drive_request(REQ_UNKNOWN_LO, '1, '1, '1);
        drive_request(REQ_UNKNOWN_HI, '1, '1, '1);
        // Push at both ends; the front push wraps the head below zero.
        drive_request(REQ_PUSH_BACK,  32'hFFFF_FFFF, '0, '0);
        drive_request(REQ_PUSH_FRONT, 32'h0000_0000, '0, '0);
        drive_request(REQ_PUSH_FRONT, 32'h1234_5678, '0, '0);
        drive_request(REQ_PEEK_FRONT, '0, '0, '0);
        drive_request(REQ_PEEK_BACK,  '0, '0, '0);
        drive_request(REQ_READ_INDEX, '0, 10'd1, '0);
        drive_request(REQ_READ_INDEX, '0, 10'd3, '0);
        drive_request(REQ_POP_BACK,   '0, '0, '0);
        drive_request(REQ_POP_FRONT,  '0, '0, '0);
        // Grow to exactly the capacity, then hit the full cases.
        drive_request(REQ_RESIZE,     32'hA5A5_5A5A, '0, NEW_LENGTH_W'(DEPTH));
        drive_request(REQ_PUSH_BACK,  32'h0F0F_0F0F, '0, '0);
        drive_request(REQ_PUSH_FRONT, 32'hF0F0_F0F0, '0, '0);
        drive_request(REQ_READ_INDEX, '0, '1, '0);
        drive_request(REQ_RESIZE,     '0, '0, '1);
        drive_request(REQ_RESIZE,     '0, '0, NEW_LENGTH_W'(DEPTH));
        drive_request(REQ_RESIZE,     '0, '0, 11'd2);
        drive_request(REQ_CLEAR,      '0, '0, '0);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 150 == 0)
                mode = phase_mode_t'($urandom_range(0, 2));
            // Long output stall while the sender keeps offering items.
            if (n == 300)
                rx_hold = 400;
            tx_calm = (n >= 300 && n < 400) || (n >= 600 && n < 900);
            rx_calm = (n >= 600 && n < 900);
            // Sender stops until the block has answered everything.
            if (n == 1200) begin
                s_axis_tvalid <= 1'b0;
                @(posedge aclk);
                while (board.pending() != 0)
                    @(posedge aclk);
            end

            held  = board.held;
            value = $urandom();
            pos   = POSITION_W'($urandom_range(0, 1023));
            len   = NEW_LENGTH_W'($urandom_range(0, 2047));
            push_cut = (mode == MODE_FILL) ? 55 : (mode == MODE_DRAIN) ? 12 : 30;
            pop_cut  = push_cut + ((mode == MODE_DRAIN) ? 55 : (mode == MODE_FILL) ? 10 : 25);
            roll = $urandom_range(0, 99);
            if (roll < push_cut) begin
                req = $urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK;
            end else if (roll < pop_cut) begin
                req = $urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK;
            end else begin
                roll = $urandom_range(0, 19);
                if (roll < 3)
                    req = REQ_PEEK_FRONT;
                else if (roll < 6)
                    req = REQ_PEEK_BACK;
                else if (roll < 12)
                    req = REQ_READ_INDEX;
                else if (roll < 17)
                    req = REQ_RESIZE;
                else if (roll == 17 && mode != MODE_FILL)
                    req = REQ_CLEAR;
                else
                    req = REQ_TYPE_W'($urandom_range(REQ_UNKNOWN_LO, REQ_UNKNOWN_HI));
            end

            // Most indexed reads land inside the count.
            if (req == REQ_READ_INDEX && held > 0 && $urandom_range(0, 3) != 0)
                pos = POSITION_W'($urandom_range(0, held - 1));
            // Resizes mostly stay near the count so growing stays cheap.
            if (req == REQ_RESIZE) begin
                roll = $urandom_range(0, 99);
                if (roll < 55)
                    len = NEW_LENGTH_W'(held + $urandom_range(0, 6));
                else if (roll < 78)
                    len = NEW_LENGTH_W'($urandom_range(0, held));
                else if (roll < 92)
                    len = (mode == MODE_FILL) ? NEW_LENGTH_W'($urandom_range(900, DEPTH))
                                              : NEW_LENGTH_W'($urandom_range(0, DEPTH));
            end
            drive_request(req, value, pos, len);
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.errors == 0 && board.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
